### hw/rtl/lmss_pkg.sv
// shared types and constants for the led matrix scan sigma-delta unit
// no dependencies; imported by lmss_scan_seq and the top level
package lmss_pkg;

    // default matrix size
    localparam int LMSS_MATRIX_HEIGHT = 8;
    localparam int LMSS_MATRIX_WIDTH  = 64;

    // multiplex ways and field widths
    localparam int          LMSS_PHASES     = 4;
    localparam int          LMSS_PHASE_W    = 2;
    localparam int          LMSS_PIX_W      = 8;
    localparam int          LMSS_FRAME_W    = 32;
    localparam logic [1:0]  LMSS_LAST_PHASE = 2'(LMSS_PHASES - 1);

    // request operation codes
    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_SCAN  = 1'b1
    } lmss_op_t;

    // memory clear sweep after reset, then normal operation
    typedef enum logic
    {
        ST_CLEAR = 1'b0,
        ST_RUN   = 1'b1
    } lmss_state_t;

    // per-step scan information that travels with a scan request
    typedef struct packed
    {
        logic [LMSS_PHASE_W-1:0] phase;
        logic                    latch;
        logic                    fend;
        logic [LMSS_FRAME_W-1:0] fnum;
    } lmss_scan_t;

endpackage

### hw/rtl/lmss_ram.sv
// generic simple dual-port ram: one write port, one read port
// registered read data; no dependencies
module lmss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/lmss_scan_seq.sv
// scan position sequencer: phase, row, column and frame counter
// depends on lmss_pkg
module lmss_scan_seq
    import lmss_pkg::*;
#(
    parameter int MATRIX_HEIGHT = LMSS_MATRIX_HEIGHT,
    parameter int MATRIX_WIDTH  = LMSS_MATRIX_WIDTH,
    parameter int ADDR_W        = $clog2(MATRIX_HEIGHT * MATRIX_WIDTH)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    output logic [ADDR_W-1:0] addr,
    output lmss_scan_t        info
);

    localparam int ROW_W  = $clog2(MATRIX_HEIGHT);
    localparam int ROW_XW = ROW_W + 1;
    localparam int COL_W  = (MATRIX_WIDTH > 1) ? $clog2(MATRIX_WIDTH) : 1;

    logic [LMSS_PHASE_W-1:0] scan_phase_reg, scan_phase_next;
    logic [ROW_W-1:0]        scan_row_reg, scan_row_next;
    logic [COL_W-1:0]        scan_col_reg, scan_col_next;
    logic [LMSS_FRAME_W-1:0] frame_count_reg, frame_count_next;

    logic [ROW_XW-1:0]       row_plus;
    logic                    col_last;
    logic                    phase_done;
    logic                    frame_done;

    // linear pixel index, row major
    assign addr = ADDR_W'(int'(scan_row_reg) * MATRIX_WIDTH + int'(scan_col_reg));

    assign col_last   = (scan_col_reg == COL_W'(MATRIX_WIDTH - 1));
    assign row_plus   = ROW_XW'(scan_row_reg) + ROW_XW'(LMSS_PHASES);
    assign phase_done = col_last && (row_plus >= ROW_XW'(MATRIX_HEIGHT));
    assign frame_done = phase_done && (scan_phase_reg == LMSS_LAST_PHASE);

    assign info.phase = scan_phase_reg;
    assign info.latch = phase_done;
    assign info.fend  = frame_done;
    assign info.fnum  = frame_done ? frame_count_reg : '0;

    always_comb
    begin
        scan_phase_next  = scan_phase_reg;
        scan_row_next    = scan_row_reg;
        scan_col_next    = scan_col_reg;
        frame_count_next = frame_count_reg;
        if (step)
        begin
            scan_col_next = scan_col_reg + COL_W'(1);
            if (col_last)
            begin
                scan_col_next = '0;
                scan_row_next = row_plus[ROW_W-1:0];
                if (phase_done)
                begin
                    scan_phase_next = scan_phase_reg + LMSS_PHASE_W'(1);
                    scan_row_next   = ROW_W'(scan_phase_next);
                end
                if (frame_done)
                begin
                    frame_count_next = frame_count_reg + LMSS_FRAME_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_phase_reg  <= '0;
            scan_row_reg    <= '0;
            scan_col_reg    <= '0;
            frame_count_reg <= '0;
        end
        else
        begin
            scan_phase_reg  <= scan_phase_next;
            scan_row_reg    <= scan_row_next;
            scan_col_reg    <= scan_col_next;
            frame_count_reg <= frame_count_next;
        end
    end

endmodule

### hw/rtl/led_matrix_scan_sigma_delta_unit.sv
// top level of the led matrix scan sigma-delta unit
// depends on lmss_pkg, lmss_ram and lmss_scan_seq
//
// usage:
//   request channel (req_valid / req_ready) carries either a brightness
//   write (operation = write) or one scan step (operation = scan)
//   response channel (rsp_valid / rsp_ready) carries one result per scan
//   step, in request order; writes give no response
//   a write outside the matrix is dropped silently
// timing:
//   one request per cycle sustained while responses are taken; a scan
//   response passes the read stage (memory read at the edge that takes
//   its request) and then the output register (add), where it is taken
//   brightness and accumulator live in two ram instances, read in the
//   request cycle, accumulator written back when the step leaves the
//   read stage
// reset:
//   scan position and frame counter clear at once; then both rams are
//   swept to zero, one pixel per cycle, all MATRIX_HEIGHT*MATRIX_WIDTH
//   pixels (512 by default), with req_ready low
// stall:
//   a stalled response holds in the output register; one more scan step
//   waits in the read stage, then req_ready drops
module led_matrix_scan_sigma_delta_unit
    import lmss_pkg::*;
#(
    parameter int MATRIX_HEIGHT = LMSS_MATRIX_HEIGHT,
    parameter int MATRIX_WIDTH  = LMSS_MATRIX_WIDTH
) (
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    req_valid,
    output logic                    req_ready,
    input  logic                    operation,
    input  logic [2:0]              pixel_row,
    input  logic [5:0]              pixel_col,
    input  logic [LMSS_PIX_W-1:0]   pixel_value,

    output logic                    rsp_valid,
    input  logic                    rsp_ready,
    output logic                    column_data,
    output logic [LMSS_PHASE_W-1:0] row_phase,
    output logic [LMSS_PHASE_W-1:0] row_select_low,
    output logic                    latch_and_show,
    output logic                    frame_end,
    output logic [LMSS_FRAME_W-1:0] frame_number
);

    localparam int PIXELS = MATRIX_HEIGHT * MATRIX_WIDTH;
    localparam int ADDR_W = $clog2(PIXELS);

    // clear sweep control
    lmss_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] clear_addr_reg, clear_addr_next;
    logic              clearing;
    logic              clear_last;

    // request decode
    logic              req_take;
    logic              scan_take;
    logic              write_take;
    logic              write_in_range;
    logic [ADDR_W-1:0] write_addr;

    // scan sequencer
    logic [ADDR_W-1:0] scan_addr;
    lmss_scan_t        scan_info;

    // read stage
    logic              s1_valid_reg, s1_valid_next;
    logic [ADDR_W-1:0] s1_addr_reg;
    lmss_scan_t        s1_info_reg;
    logic              s1_adv;

    // memory ports
    logic [LMSS_PIX_W-1:0] bright_rd;
    logic [LMSS_PIX_W-1:0] acc_rd;
    logic                  bright_we;
    logic [ADDR_W-1:0]     bright_waddr;
    logic [LMSS_PIX_W-1:0] bright_wdata;
    logic                  acc_we;
    logic [ADDR_W-1:0]     acc_waddr;
    logic [LMSS_PIX_W-1:0] acc_wdata;
    logic [LMSS_PIX_W:0]   acc_sum;

    // output register
    logic                    rsp_valid_reg, rsp_valid_next;
    logic                    column_data_reg;
    lmss_scan_t              rsp_info_reg;

    //--------------------------------------------------------------------
    // clear sweep: next state
    //--------------------------------------------------------------------
    assign clear_last = (clear_addr_reg == ADDR_W'(PIXELS - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                state_next = ST_RUN;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // clear sweep: outputs
    always_comb
    begin
        clearing        = 1'b0;
        clear_addr_next = clear_addr_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clearing        = 1'b1;
                clear_addr_next = clear_addr_reg + ADDR_W'(1);
            end
            ST_RUN:
            begin
                clearing = 1'b0;
            end
            default:
            begin
                clearing = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    //--------------------------------------------------------------------
    // request acceptance
    //--------------------------------------------------------------------
    // read stage moves on when the output register is free or being drained
    assign s1_adv    = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !clearing && (!s1_valid_reg || s1_adv);

    assign req_take   = req_valid && req_ready;
    assign scan_take  = req_take && (operation == OP_SCAN);
    assign write_take = req_take && (operation == OP_WRITE);

    assign write_in_range = (32'(pixel_row) < 32'(MATRIX_HEIGHT))
                         && (32'(pixel_col) < 32'(MATRIX_WIDTH));
    assign write_addr = ADDR_W'(int'(pixel_row) * MATRIX_WIDTH + int'(pixel_col));

    //--------------------------------------------------------------------
    // scan position
    //--------------------------------------------------------------------
    lmss_scan_seq #(
        .MATRIX_HEIGHT (MATRIX_HEIGHT),
        .MATRIX_WIDTH  (MATRIX_WIDTH),
        .ADDR_W        (ADDR_W)
    ) u_scan_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (scan_take),
        .addr  (scan_addr),
        .info  (scan_info)
    );

    //--------------------------------------------------------------------
    // frame store and accumulators
    //--------------------------------------------------------------------
    // a brightness write lands at its own edge, so any later scan read sees it
    assign bright_we    = clearing || (write_take && write_in_range);
    assign bright_waddr = clearing ? clear_addr_reg : write_addr;
    assign bright_wdata = clearing ? '0 : pixel_value;

    lmss_ram #(
        .WIDTH (LMSS_PIX_W),
        .DEPTH (PIXELS)
    ) u_bright_ram (
        .clk   (clk),
        .we    (bright_we),
        .waddr (bright_waddr),
        .wdata (bright_wdata),
        .re    (scan_take),
        .raddr (scan_addr),
        .rdata (bright_rd)
    );

    // sigma-delta add; carry out is the column bit
    assign acc_sum = {1'b0, acc_rd} + {1'b0, bright_rd};

    // a pixel comes back only after every other pixel of the frame (at least
    // four steps), so the write-back always lands before its next read
    assign acc_we    = clearing || s1_adv;
    assign acc_waddr = clearing ? clear_addr_reg : s1_addr_reg;
    assign acc_wdata = clearing ? '0 : acc_sum[LMSS_PIX_W-1:0];

    lmss_ram #(
        .WIDTH (LMSS_PIX_W),
        .DEPTH (PIXELS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .re    (scan_take),
        .raddr (scan_addr),
        .rdata (acc_rd)
    );

    //--------------------------------------------------------------------
    // read stage: ram data holds while the stage waits, read enable is off
    //--------------------------------------------------------------------
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (scan_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_take)
        begin
            s1_addr_reg <= scan_addr;
            s1_info_reg <= scan_info;
        end
    end

    //--------------------------------------------------------------------
    // output register
    //--------------------------------------------------------------------
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (s1_adv)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            column_data_reg <= acc_sum[LMSS_PIX_W];
            rsp_info_reg    <= s1_info_reg;
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign column_data    = column_data_reg;
    assign row_phase      = rsp_info_reg.phase;
    assign row_select_low = ~rsp_info_reg.phase;
    assign latch_and_show = rsp_info_reg.latch;
    assign frame_end      = rsp_info_reg.fend;
    assign frame_number   = rsp_info_reg.fnum;

    //--------------------------------------------------------------------
    // assertions
    //--------------------------------------------------------------------
    // nothing is in flight while the memories are being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> (!s1_valid_reg && !rsp_valid_reg))
        else $error("scan step in flight during clear sweep");

    // a waiting step in the read stage is never dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && rsp_valid_reg && !rsp_ready) |=> s1_valid_reg)
        else $error("read stage lost a step under stall");

    // accumulator write-back only for a step that leaves the read stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (acc_we && !clearing) |-> s1_valid_reg)
        else $error("accumulator written without a scan step");

    // frame end only on the last bit of phase three
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && frame_end) |-> (latch_and_show && (row_phase == LMSS_LAST_PHASE)))
        else $error("frame end outside last bit of last phase");

endmodule
